// File: hw/rtl/mbsp_pkg.sv
package mbsp_pkg;

  // Width of one MIDI byte and of a data byte without its status flag.
  localparam int unsigned ByteW = 8;
  localparam int unsigned DataW = 7;
  localparam int unsigned LenW  = 2;

  // Expected data lengths.
  localparam logic [LenW-1:0] LEN_NONE = 2'd0;
  localparam logic [LenW-1:0] LEN_ONE  = 2'd1;
  localparam logic [LenW-1:0] LEN_TWO  = 2'd2;

  // Low nibble of the system common status bytes (high nibble F).
  localparam logic [3:0] SYS_EX_START  = 4'h0;
  localparam logic [3:0] SYS_TIME_CODE = 4'h1;
  localparam logic [3:0] SYS_SONG_POS  = 4'h2;
  localparam logic [3:0] SYS_SONG_SEL  = 4'h3;
  localparam logic [3:0] SYS_TUNE_REQ  = 4'h6;
  localparam logic [3:0] SYS_EX_END    = 4'h7;

  // High nibbles.
  localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
  localparam logic [3:0] HI_SYSTEM      = 4'hF;

  // Top five bits shared by every real-time byte (F8 to FF).
  localparam logic [4:0] REALTIME_TOP = 5'b11111;

  localparam logic [ByteW-1:0] TUNE_REQUEST = 8'hF6;

  // One completed message; the first member sits in the highest bits, so the
  // status byte lands in the lowest bits once the struct is packed.
  typedef struct packed {
    logic [LenW-1:0]  length;
    logic [DataW-1:0] data2;
    logic [DataW-1:0] data1;
    logic [ByteW-1:0] status;
  } msg_t;

  localparam int unsigned MsgW = $bits(msg_t);

endpackage

// File: hw/rtl/midi_byte_stream_parser.sv
// Path: a result request is offered on the out_ channel once its byte has
// moved from the input register to the result register.
// Throughput: one byte per cycle while the result side keeps out_tready high.
// Reset: rst_n is synchronous and active low; it empties both registers,
// clears running status, the data count, the expected length and the
// exclusive flag, so data bytes are ignored until a status byte arrives.
module midi_byte_stream_parser
  import mbsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [ByteW-1:0] in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [MsgW-1:0]  out_tdata   // [7:0] msg_status, [14:8] msg_data1,
                                       // [21:15] msg_data2, [23:22] msg_length
);

  // Input register: holds one received byte until the parser can act on it.
  logic             in_valid_r;
  logic [ByteW-1:0] in_byte_r;

  // Result register: one completed message waiting to be taken.
  logic             out_valid_r;
  msg_t             out_msg_r;

  // Parser state.
  logic [ByteW-1:0] run_status_r, run_status_nxt;
  logic [LenW-1:0]  data_cnt_r, data_cnt_nxt;
  logic [LenW-1:0]  exp_len_r, exp_len_nxt;
  logic             in_sysex_r, in_sysex_nxt;
  logic [DataW-1:0] first_data_r, first_data_nxt;

  logic             emit;
  msg_t             msg_nxt;
  logic             advance;
  logic [LenW-1:0]  cnt_inc;

  // The held byte is processed when the result register is free or is being
  // emptied in this cycle. A new request is taken whenever the input register
  // is empty or its byte moves on.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  assign cnt_inc = data_cnt_r + LEN_ONE;

  // Parser decision for the byte in the input register.
  always_comb begin
    run_status_nxt = run_status_r;
    data_cnt_nxt   = data_cnt_r;
    exp_len_nxt    = exp_len_r;
    in_sysex_nxt   = in_sysex_r;
    first_data_nxt = first_data_r;
    emit           = 1'b0;
    msg_nxt        = '{length: LEN_NONE, data2: '0, data1: '0, status: in_byte_r};

    if (in_byte_r[ByteW-1]) begin
      if (in_byte_r[7:3] == REALTIME_TOP) begin
        // Real-time bytes go straight out and leave running status alone.
        emit = 1'b1;
      end else if (in_byte_r[7:4] == HI_SYSTEM) begin
        unique case (in_byte_r[3:0])
          SYS_EX_START: begin
            in_sysex_nxt = 1'b1;
          end
          SYS_TIME_CODE, SYS_SONG_SEL: begin
            in_sysex_nxt   = 1'b0;
            run_status_nxt = in_byte_r;
            data_cnt_nxt   = '0;
            exp_len_nxt    = LEN_ONE;
          end
          SYS_SONG_POS: begin
            in_sysex_nxt   = 1'b0;
            run_status_nxt = in_byte_r;
            data_cnt_nxt   = '0;
            exp_len_nxt    = LEN_TWO;
          end
          SYS_TUNE_REQ: begin
            in_sysex_nxt = 1'b0;
            emit         = 1'b1;
          end
          SYS_EX_END: begin
            in_sysex_nxt = 1'b0;
          end
          default: begin
            // Undefined system common bytes change nothing.
          end
        endcase
      end else begin
        // Channel status byte.
        in_sysex_nxt   = 1'b0;
        run_status_nxt = in_byte_r;
        data_cnt_nxt   = '0;
        exp_len_nxt    = (in_byte_r[7:4] == HI_PROG_CHANGE ||
                          in_byte_r[7:4] == HI_CHAN_PRESS) ? LEN_ONE : LEN_TWO;
      end
    end else if (!in_sysex_r && exp_len_r != LEN_NONE) begin
      // Data byte under running status.
      if (cnt_inc >= exp_len_r) begin
        data_cnt_nxt = '0;
        emit         = 1'b1;
        msg_nxt.status = run_status_r;
        if (exp_len_r == LEN_ONE) begin
          msg_nxt.length = LEN_ONE;
          msg_nxt.data1  = in_byte_r[DataW-1:0];
        end else begin
          msg_nxt.length = LEN_TWO;
          msg_nxt.data1  = first_data_r;
          msg_nxt.data2  = in_byte_r[DataW-1:0];
        end
      end else begin
        data_cnt_nxt   = cnt_inc;
        first_data_nxt = in_byte_r[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      run_status_r <= '0;
      data_cnt_r   <= '0;
      exp_len_r    <= LEN_NONE;
      in_sysex_r   <= 1'b0;
      first_data_r <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        run_status_r <= run_status_nxt;
        data_cnt_r   <= data_cnt_nxt;
        exp_len_r    <= exp_len_nxt;
        in_sysex_r   <= in_sysex_nxt;
        first_data_r <= first_data_nxt;
        out_valid_r  <= emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (advance && emit) begin
      out_msg_r <= msg_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_msg_r;

endmodule

// File: hw/rtl/mbsp_checker.sv
module mbsp_checker
  import mbsp_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [ByteW-1:0] in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [MsgW-1:0]  out_tdata
);

  msg_t msg;
  assign msg = out_tdata;

  // A stalled result request keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result request changed while stalled");

  // Every message carries a status byte and never more than two data bytes.
  a_status_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> msg.status[ByteW-1] && msg.length <= LEN_TWO)
    else $error("malformed status or length");

  // Data bytes that are absent read as zero.
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (msg.length == LEN_TWO || msg.data2 == '0) &&
                   (msg.length != LEN_NONE || msg.data1 == '0))
    else $error("absent data byte not zero");

  // Only real-time bytes and Tune Request leave as one-byte messages.
  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && msg.length == LEN_NONE |->
      msg.status[7:3] == REALTIME_TOP || msg.status == TUNE_REQUEST)
    else $error("unexpected message without data");

  // A data byte taken with an empty pipeline cannot be a one-byte message.
  a_data_no_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tdata[ByteW-1] && !out_tvalid ##1 !out_tvalid
      |=> !(out_tvalid && msg.length == LEN_NONE && $past(!out_tvalid, 2) &&
            msg.status != TUNE_REQUEST && msg.status[7:3] != REALTIME_TOP))
    else $error("data byte produced a one-byte message");

endmodule

bind midi_byte_stream_parser mbsp_checker u_mbsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: test/midi_byte_stream_parser_tb.sv
module midi_byte_stream_parser_tb;
  import mbsp_pkg::*;

  // Real-time bytes occupy F8 to FF; any byte from here up is passed straight on.
  localparam logic [ByteW-1:0] REALTIME_BASE = 8'hF8;
  localparam logic [ByteW-1:0] SYSEX_START   = 8'hF0;
  localparam logic [ByteW-1:0] SYSEX_END     = 8'hF7;
  localparam logic [ByteW-1:0] TIME_CODE     = 8'hF1;
  localparam logic [ByteW-1:0] SONG_POS      = 8'hF2;
  localparam logic [ByteW-1:0] SONG_SEL      = 8'hF3;
  localparam logic [ByteW-1:0] UNDEF_F4      = 8'hF4;
  localparam logic [ByteW-1:0] UNDEF_F5      = 8'hF5;
  localparam logic [ByteW-1:0] CHAN_FIRST    = 8'h80;
  localparam logic [ByteW-1:0] CHAN_LAST     = 8'hEF;

  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 650;
  localparam int MAX_REPORTS  = 100;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [ByteW-1:0] in_tdata = '0;    // [7:0] rx_byte
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [MsgW-1:0]  out_tdata;        // [7:0] status, [14:8] data1, [21:15] data2,
                                      // [23:22] length

  midi_byte_stream_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Bytes waiting to be offered and messages the parser still owes us.
  logic [ByteW-1:0] tx_bytes[$];
  msg_t             due_msgs[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_armed = 1'b0;
  int n_errors = 0;
  int n_pushed = 0;

  // Shadow of the parser state, advanced once per accepted request.
  logic [ByteW-1:0] cur_status   = '0;
  logic [LenW-1:0]  data_seen    = '0;
  logic [LenW-1:0]  want_len     = LEN_NONE;
  logic             sysex_active = 1'b0;
  logic [DataW-1:0] held_data1   = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    end
  endtask

  function automatic void set_running(logic [ByteW-1:0] rx, logic [LenW-1:0] len);
    sysex_active = 1'b0;
    cur_status   = rx;
    data_seen    = '0;
    want_len     = len;
  endfunction

  // Works out what one received byte does to the parser and what, if
  // anything, it must emit.
  function automatic void predict_byte(logic [ByteW-1:0] rx);
    msg_t m;
    m = '0;
    if (rx[7]) begin
      if (rx >= REALTIME_BASE) begin
        m.status = rx;
        due_msgs.push_back(m);
      end else if (rx[7:4] == HI_SYSTEM) begin
        case (rx[3:0])
          SYS_EX_START: sysex_active = 1'b1;
          SYS_TIME_CODE, SYS_SONG_SEL: set_running(rx, LEN_ONE);
          SYS_SONG_POS: set_running(rx, LEN_TWO);
          SYS_TUNE_REQ: begin
            sysex_active = 1'b0;
            m.status = rx;
            due_msgs.push_back(m);
          end
          SYS_EX_END: sysex_active = 1'b0;
          default: ;
        endcase
      end else begin
        set_running(rx, (rx[7:4] == HI_PROG_CHANGE || rx[7:4] == HI_CHAN_PRESS) ?
                        LEN_ONE : LEN_TWO);
      end
    end else if (!sysex_active && want_len != LEN_NONE) begin
      data_seen = data_seen + 2'd1;
      if (data_seen >= want_len) begin
        data_seen = '0;
        m.status = cur_status;
        m.length = want_len;
        if (want_len == LEN_ONE) begin
          m.data1 = rx[DataW-1:0];
        end else begin
          m.data1 = held_data1;
          m.data2 = rx[DataW-1:0];
        end
        due_msgs.push_back(m);
      end else begin
        held_data1 = rx[DataW-1:0];
      end
    end
  endfunction

  task automatic push_byte(logic [ByteW-1:0] rx);
    tx_bytes.push_back(rx);
    n_pushed++;
  endtask

  // Mostly well-formed messages with running status repeats, with real-time
  // bytes scattered through them, some exclusive runs, and a share of noise.
  task automatic gen_traffic(int n_items);
    int start, pick, reps, len, k;
    logic [ByteW-1:0] st;
    start = n_pushed;
    while (n_pushed - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 99) < 85) begin
          st = 8'($urandom_range(CHAN_FIRST, CHAN_LAST));
        end else begin
          st = 8'($urandom_range(TIME_CODE, SONG_SEL));
        end
        len = (st[7:4] == HI_PROG_CHANGE || st[7:4] == HI_CHAN_PRESS ||
               st == TIME_CODE || st == SONG_SEL) ? 1 : 2;
        push_byte(st);
        reps = $urandom_range(1, 3);
        for (int r = 0; r < reps * len; r++) begin
          if ($urandom_range(0, 9) == 0) begin
            push_byte(8'($urandom_range(REALTIME_BASE, 8'hFF)));
          end
          push_byte(8'($urandom_range(0, 127)));
        end
      end else if (pick < 70) begin
        push_byte(SYSEX_START);
        k = $urandom_range(0, 6);
        for (int i = 0; i < k; i++) begin
          case ($urandom_range(0, 9))
            0: push_byte(8'($urandom_range(REALTIME_BASE, 8'hFF)));
            1: push_byte(8'($urandom_range(UNDEF_F4, UNDEF_F5)));
            default: push_byte(8'($urandom_range(0, 127)));
          endcase
        end
        // Usually a proper end; otherwise Tune Request or the next status ends it.
        case ($urandom_range(0, 4))
          0: push_byte(TUNE_REQUEST);
          1: ;
          default: push_byte(SYSEX_END);
        endcase
      end else if (pick < 80) begin
        push_byte(($urandom_range(0, 4) == 0) ? TUNE_REQUEST :
                  8'($urandom_range(REALTIME_BASE, 8'hFF)));
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Driver: offers queued bytes, keeping a request steady until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid    <= 1'b0;
      in_tdata     <= '0;
      cur_status   = '0;
      data_seen    = '0;
      want_len     = LEN_NONE;
      sysex_active = 1'b0;
      held_data1   = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_byte(in_tdata);
      end
      if (!in_tvalid || in_tready) begin
        if (tx_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= tx_bytes.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted message against the oldest one owed and
  // paces out_tready, including one long hold-off to back the parser up.
  int hold_left = 0;
  always @(posedge clk) begin : monitor
    msg_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (due_msgs.size() == 0) begin
          report_mismatch("unexpected message status", 32'(got.status), 0);
        end else begin
          want = due_msgs.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.data1 !== want.data1)
            report_mismatch("data1", 32'(got.data1), 32'(want.data1));
          if (got.data2 !== want.data2)
            report_mismatch("data2", 32'(got.data2), 32'(want.data2));
          if (got.length !== want.length)
            report_mismatch("length", 32'(got.length), 32'(want.length));
        end
      end
      if (hold_armed) begin
        hold_left  = HOLD_CYCLES;
        hold_armed = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any handshake on either side means a hang.
  int stall_cnt = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [ByteW-1:0] directed [0:28];
    // Data before any status; note on with running status; program change
    // repeats; real-time inside a message; an exclusive run with undefined
    // and real-time bytes in it; Tune Request and real-time extremes.
    directed = '{8'h00, 8'h7F,
                 8'h90, 8'h3C, 8'h7F, 8'h00, 8'h01,
                 8'hC5, 8'h7F, 8'h00,
                 8'hF2, 8'h00, 8'hF8, 8'h7F,
                 8'hF0, 8'h12, 8'hF4, 8'hF5, 8'hF9, 8'h34, 8'hF7, 8'h55,
                 8'hF6, 8'hFF, 8'hFD,
                 8'hF1, 8'h7F,
                 8'hE0, 8'h40};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 87;
    foreach (directed[i]) push_byte(directed[i]);
    gen_traffic(PHASE_ITEMS);
    while (tx_bytes.size() != 0) @(negedge clk);

    send_idle_pct = 87;
    recv_idle_pct = 7;
    gen_traffic(PHASE_ITEMS);
    while (tx_bytes.size() != 0) @(negedge clk);

    // No idling from here on; the opening hold-off makes the input stall.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed = 1'b1;
    gen_traffic(PHASE_ITEMS);

    while (tx_bytes.size() != 0 || in_tvalid || due_msgs.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (due_msgs.size() != 0) begin
      report_mismatch("messages never produced", 0, due_msgs.size());
    end
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: midi_byte_stream_parser.f
hw/rtl/mbsp_pkg.sv
hw/rtl/midi_byte_stream_parser.sv
hw/rtl/mbsp_checker.sv
test/midi_byte_stream_parser_tb.sv
